/* rtl/core/pbt_pkg.sv */
// Shared types and codes for the priority behavior table.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package pbt_pkg;

  localparam int unsigned ID_W   = 6;
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned MASK_W = 64;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_SELECT     = 2'd2,
    OP_RESET_WALK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_LINK,
    S_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item, start a walk at the head
    logic scan_step; // examine one slot for duplicate id and free slot
    logic walk_step; // examine one list entry
    logic link;      // perform the list update
    logic emit_take; // the pending result was transferred
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic walk_done;
    logic need_link;
    logic emit_pending;
    logic result_final;
  } stat_t;

endpackage

/* rtl/core/pbt_ctrl.sv */
// Sequencer for the priority behavior table.
// Depends on pbt_pkg for the state, command and status types.
`timescale 1ns / 1ps
module pbt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pbt_pkg::op_t  op,
  input  logic          out_ready,
  input  pbt_pkg::stat_t st,
  output pbt_pkg::cmd_t cmd,
  output logic          in_ready,
  output logic          out_valid
);
  import pbt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (op == OP_REGISTER) ? S_SCAN : S_WALK;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = st.need_link ? S_WALK : S_EMIT;
        end
      end
      S_WALK: begin
        if (st.emit_pending) begin
          state_nxt = S_EMIT;
        end else if (st.walk_done) begin
          state_nxt = st.need_link ? S_LINK : S_EMIT;
        end
      end
      S_LINK: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_ready) begin
          state_nxt = st.result_final ? S_IDLE : S_WALK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_WALK: cmd.walk_step = !st.emit_pending && !st.walk_done;
      S_LINK: cmd.link = 1'b1;
      S_EMIT: begin
        out_valid     = 1'b1;
        cmd.emit_take = out_ready;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/pbt_dp.sv */
// Datapath of the priority behavior table: entry store, walk pointers, result.
// Depends on pbt_pkg for codes and the command and status structs.
`timescale 1ns / 1ps
module pbt_dp #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pbt_pkg::cmd_t              cmd,
  input  pbt_pkg::op_t               in_operation,
  input  logic [pbt_pkg::ID_W-1:0]   in_behavior_id,
  input  logic                       in_has_reset,
  input  logic [pbt_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [pbt_pkg::MASK_W-1:0] in_request_mask,
  output pbt_pkg::stat_t             st,
  output pbt_pkg::status_t           out_status,
  output logic [pbt_pkg::ID_W-1:0]   out_result_id,
  output logic                       out_last
);
  import pbt_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = $clog2(MAX_ENTRIES);
  localparam logic [IW-1:0] END_MARK = IW'(MAX_ENTRIES);

  logic [MAX_ENTRIES-1:0] valid_r;
  logic [ID_W-1:0]        id_r    [MAX_ENTRIES];
  logic [PRIO_W-1:0]      prio_r  [MAX_ENTRIES];
  logic                   flag_r  [MAX_ENTRIES];
  logic [IW-1:0]          next_r  [MAX_ENTRIES];
  logic [IW-1:0]          head_r;

  op_t               op_r;
  logic [ID_W-1:0]   bid_r;
  logic              hr_r;
  logic [PRIO_W-1:0] pr_r;
  logic [MASK_W-1:0] mask_r;

  logic [IW-1:0] cur_r, prev_r, free_r;
  logic [IW-1:0] steps_r;
  logic          hit_r;    // walk found its target
  logic          hold_v_r; // reset walk holds a flagged entry not yet shown
  logic [ID_W-1:0] hold_id_r;
  logic          dup_r;
  logic          pend_r;   // a reset-walk entry awaits emission
  logic          done_r;

  status_t         res_st_r;
  logic [ID_W-1:0] res_id_r;
  logic            res_last_r;

  logic [SW-1:0] cs;
  logic          cur_in;
  logic          walk_end;

  assign cs       = cur_r[SW-1:0];
  assign cur_in   = (cur_r < END_MARK) && (steps_r < END_MARK);
  assign walk_end = !cur_in || hit_r;

  always_comb begin
    st              = '0;
    st.scan_done    = (steps_r == END_MARK) || dup_r;
    st.walk_done    = walk_end;
    st.need_link    = (op_r == OP_REGISTER) ? (!dup_r && free_r != END_MARK)
                    : (op_r == OP_UNREGISTER) ? hit_r : 1'b0;
    st.emit_pending = pend_r;
    st.result_final = done_r;
  end

  assign out_status    = res_st_r;
  assign out_result_id = res_id_r;
  assign out_last      = res_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      head_r   <= END_MARK;
      pend_r   <= 1'b0;
      done_r   <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r     <= in_operation;
        bid_r    <= in_behavior_id;
        hr_r     <= in_has_reset;
        pr_r     <= in_priority_req;
        mask_r   <= in_request_mask;
        cur_r    <= head_r;
        prev_r   <= END_MARK;
        free_r   <= END_MARK;
        steps_r  <= '0;
        hit_r    <= 1'b0;
        dup_r    <= 1'b0;
        hold_v_r <= 1'b0;
        pend_r   <= 1'b0;
        done_r   <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (steps_r == END_MARK || dup_r) begin
          // Scan over: form the register result and set up the insertion walk from the head.
          steps_r <= '0;
          cur_r   <= head_r;
          if (dup_r) begin
            res_st_r <= ST_DUPLICATE;
          end else if (free_r == END_MARK) begin
            res_st_r <= ST_FULL;
          end else begin
            res_st_r <= ST_DONE;
          end
          res_id_r   <= bid_r;
          res_last_r <= 1'b1;
          done_r     <= 1'b1;
        end else begin
          if (valid_r[steps_r[SW-1:0]]) begin
            if (id_r[steps_r[SW-1:0]] == bid_r) begin
              dup_r <= 1'b1;
            end
          end else if (free_r == END_MARK) begin
            free_r <= steps_r;
          end
          steps_r <= steps_r + 1'b1;
        end
      end
      if (cmd.walk_step) begin
        case (op_r)
          OP_REGISTER: begin
            if (prio_r[cs] >= pr_r) begin
              prev_r  <= cur_r;
              cur_r   <= next_r[cs];
              steps_r <= steps_r + 1'b1;
            end else begin
              hit_r <= 1'b1;
            end
          end
          OP_UNREGISTER: begin
            if (id_r[cs] != bid_r) begin
              prev_r  <= cur_r;
              cur_r   <= next_r[cs];
              steps_r <= steps_r + 1'b1;
            end else begin
              hit_r <= 1'b1;
            end
          end
          OP_SELECT: begin
            if (mask_r[id_r[cs]]) begin
              hit_r <= 1'b1;
            end else begin
              cur_r   <= next_r[cs];
              steps_r <= steps_r + 1'b1;
            end
          end
          default: begin
            // A flagged entry is held until the next one is found, so the
            // held one is known not to be the last and can be shown.
            if (flag_r[cs]) begin
              if (hold_v_r) begin
                pend_r     <= 1'b1;
                res_id_r   <= hold_id_r;
                res_st_r   <= ST_DONE;
                res_last_r <= 1'b0;
              end
              hold_v_r  <= 1'b1;
              hold_id_r <= id_r[cs];
            end
            cur_r   <= next_r[cs];
            steps_r <= steps_r + 1'b1;
          end
        endcase
      end
      // Form the final result once a walk ends (register results come from the scan).
      if (!cmd.walk_step && !cmd.load && !cmd.scan_step && !cmd.emit_take &&
          !pend_r && walk_end && !done_r) begin
        done_r     <= 1'b1;
        res_last_r <= 1'b1;
        case (op_r)
          OP_UNREGISTER: begin
            res_st_r <= hit_r ? ST_DONE : ST_NONE;
            res_id_r <= bid_r;
          end
          OP_SELECT: begin
            res_st_r <= hit_r ? ST_DONE : ST_NONE;
            res_id_r <= hit_r ? id_r[cs] : '0;
          end
          OP_RESET_WALK: begin
            res_st_r <= hold_v_r ? ST_DONE : ST_NONE;
            res_id_r <= hold_v_r ? hold_id_r : '0;
          end
          default: ;
        endcase
      end
      if (cmd.emit_take) begin
        pend_r <= 1'b0;
        done_r <= 1'b0;
      end
      if (cmd.link) begin
        if (op_r == OP_REGISTER) begin
          valid_r[free_r[SW-1:0]] <= 1'b1;
          id_r[free_r[SW-1:0]]    <= bid_r;
          prio_r[free_r[SW-1:0]]  <= pr_r;
          flag_r[free_r[SW-1:0]]  <= hr_r;
          next_r[free_r[SW-1:0]]  <= cur_r;
          if (prev_r == END_MARK) begin
            head_r <= free_r;
          end else begin
            next_r[prev_r[SW-1:0]] <= free_r;
          end
        end else begin
          valid_r[cs] <= 1'b0;
          if (prev_r == END_MARK) begin
            head_r <= next_r[cs];
          end else begin
            next_r[prev_r[SW-1:0]] <= next_r[cs];
          end
        end
      end
    end
  end

endmodule

/* rtl/core/priority_behavior_table_core.sv */
// Priority behavior table: a linked list of behaviors in descending priority.
// A register first scans every slot for a duplicate id and a free slot, then walks the
// list to its place, links the new entry and shows the result (duplicate or full: shown
// after the scan). Unregister and select walk the list and show the result, an unregister
// linking out a found entry first; a reset walk examines every entry and shows each flagged one.
// One item at a time: a new item is taken only after the last result is transferred. Reset empties the list.
`timescale 1ns / 1ps
module priority_behavior_table_core #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_operation,
  input  logic [pbt_pkg::ID_W-1:0]   in_behavior_id,
  input  logic                       in_has_reset,
  input  logic [pbt_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [pbt_pkg::MASK_W-1:0] in_request_mask,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_status,
  output logic [pbt_pkg::ID_W-1:0]   out_result_id,
  output logic                       out_last
);
  import pbt_pkg::*;

  // The controller sequences scan, walk, link and emit steps; the datapath
  // holds the table and the walk pointers and reports when each step ends.
  cmd_t    cmd;
  stat_t   st;
  status_t res_st;

  assign out_status = res_st;

  pbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .op       (op_t'(in_operation)),
    .out_ready(out_ready),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_valid(out_valid)
  );

  pbt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_operation   (op_t'(in_operation)),
    .in_behavior_id (in_behavior_id),
    .in_has_reset   (in_has_reset),
    .in_priority_req(in_priority_req),
    .in_request_mask(in_request_mask),
    .st             (st),
    .out_status     (res_st),
    .out_result_id  (out_result_id),
    .out_last       (out_last)
  );

endmodule

/* rtl/core/pbt_checker.sv */
// Port-level checks for the priority behavior table.
// Bound to priority_behavior_table_core; takes the status codes from pbt_pkg.
`timescale 1ns / 1ps
module pbt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_last
);
  import pbt_pkg::*;

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result shown");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NONE |-> out_last) else $error("none not last");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
endmodule

bind priority_behavior_table_core pbt_checker u_pbt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_last(out_last)
);

/* tb/tb_priority_behavior_table_core.sv */
// Self-checking testbench for priority_behavior_table_core: a linked behavior table
// driven through valid/ready channels. Depends on pbt_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb_priority_behavior_table_core;
  import pbt_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned NIL   = SLOTS;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [5:0]  in_behavior_id;
  logic        in_has_reset;
  logic [15:0] in_priority_req;
  logic [63:0] in_request_mask;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [5:0]  out_result_id;
  logic        out_last;

  priority_behavior_table_core #(.MAX_ENTRIES(SLOTS)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_behavior_id(in_behavior_id),
    .in_has_reset(in_has_reset), .in_priority_req(in_priority_req),
    .in_request_mask(in_request_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_result_id(out_result_id), .out_last(out_last)
  );

  // One expected result transfer.
  typedef struct packed {
    status_t    status;
    logic [5:0] id;
    logic       last;
  } reply_t;

  // The testbench's own copy of the behavior table.
  logic        tbl_valid [SLOTS];
  logic [5:0]  tbl_id    [SLOTS];
  logic [15:0] tbl_prio  [SLOTS];
  logic        tbl_flag  [SLOTS];
  int unsigned tbl_next  [SLOTS];
  int unsigned tbl_head;

  reply_t pending_replies[$];
  int     error_count;
  int     send_idle_pct;
  int     recv_stall_pct;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic status_t table_register(logic [5:0] id, logic flag, logic [15:0] prio);
    int unsigned free_slot;
    int unsigned prev;
    int unsigned cur;
    int unsigned steps;
    free_slot = NIL;
    prev = NIL;
    cur = tbl_head;
    steps = 0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_id[i] == id) return ST_DUPLICATE;
      end else if (free_slot == NIL) begin
        free_slot = i;
      end
    end
    if (free_slot == NIL) return ST_FULL;
    // Equal priorities keep registration order: stop only at a strictly lower one.
    while (cur < NIL && steps < SLOTS && tbl_prio[cur] >= prio) begin
      prev = cur;
      cur = tbl_next[cur];
      steps++;
    end
    tbl_valid[free_slot] = 1'b1;
    tbl_id[free_slot] = id;
    tbl_prio[free_slot] = prio;
    tbl_flag[free_slot] = flag;
    tbl_next[free_slot] = cur;
    if (prev == NIL) tbl_head = free_slot;
    else tbl_next[prev] = free_slot;
    return ST_DONE;
  endfunction

  function automatic status_t table_unregister(logic [5:0] id);
    int unsigned prev;
    int unsigned cur;
    int unsigned steps;
    prev = NIL;
    cur = tbl_head;
    steps = 0;
    while (cur < NIL && steps < SLOTS && tbl_id[cur] != id) begin
      prev = cur;
      cur = tbl_next[cur];
      steps++;
    end
    if (cur >= NIL || steps >= SLOTS) return ST_NONE;
    // Removing the head keeps the rest of the list linked.
    if (prev == NIL) tbl_head = tbl_next[cur];
    else tbl_next[prev] = tbl_next[cur];
    tbl_valid[cur] = 1'b0;
    tbl_id[cur] = '0;
    tbl_prio[cur] = '0;
    tbl_flag[cur] = 1'b0;
    tbl_next[cur] = 0;
    return ST_DONE;
  endfunction

  // Works out the results of one accepted transfer and queues them.
  task automatic predict_table_op(op_t op, logic [5:0] id, logic flag, logic [15:0] prio,
                                  logic [63:0] mask);
    int unsigned cur;
    int unsigned steps;
    int          n;
    reply_t      r;
    cur = tbl_head;
    steps = 0;
    n = 0;
    case (op)
      OP_REGISTER: begin
        r.status = table_register(id, flag, prio);
        r.id = id;
        r.last = 1'b1;
        pending_replies.push_back(r);
      end
      OP_UNREGISTER: begin
        r.status = table_unregister(id);
        r.id = id;
        r.last = 1'b1;
        pending_replies.push_back(r);
      end
      OP_SELECT: begin
        r.status = ST_NONE;
        r.id = '0;
        r.last = 1'b1;
        while (cur < NIL && steps < SLOTS) begin
          if (mask[tbl_id[cur]]) begin
            r.status = ST_DONE;
            r.id = tbl_id[cur];
            break;
          end
          cur = tbl_next[cur];
          steps++;
        end
        pending_replies.push_back(r);
      end
      default: begin
        while (cur < NIL && steps < SLOTS) begin
          if (tbl_flag[cur]) begin
            r.status = ST_DONE;
            r.id = tbl_id[cur];
            r.last = 1'b0;
            pending_replies.push_back(r);
            n++;
          end
          cur = tbl_next[cur];
          steps++;
        end
        if (n == 0) begin
          r.status = ST_NONE;
          r.id = '0;
          r.last = 1'b1;
          pending_replies.push_back(r);
        end else begin
          r = pending_replies.pop_back();
          r.last = 1'b1;
          pending_replies.push_back(r);
        end
      end
    endcase
  endtask

  // Sends one item; the prediction is made at the accepting edge, in order.
  task automatic send_item(op_t op, logic [5:0] id, logic flag, logic [15:0] prio,
                           logic [63:0] mask);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_operation <= op;
    in_behavior_id <= id;
    in_has_reset <= flag;
    in_priority_req <= prio;
    in_request_mask <= mask;
    do @(posedge clk); while (!in_ready);
    predict_table_op(op, id, flag, prio, mask);
    in_valid <= 1'b0;
    // The block is busy after a transfer until its last result is taken, so
    // stepping an edge here loses no acceptance.
    @(posedge clk);
  endtask

  // Random receiver backpressure; ready is updated once per edge.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
  end

  // Checks each result transfer against the oldest expectation.
  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result id %0d", out_result_id));
      end else begin
        e = pending_replies.pop_front();
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, e.status));
        if (out_result_id !== e.id)
          report_mismatch($sformatf("id %0d, want %0d", out_result_id, e.id));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %0b, want %0b", out_last, e.last));
      end
    end
  end

  task automatic wait_drained();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_mask();
    return {$urandom(), $urandom()};
  endfunction

  // Extremes of every field, full and duplicate cases, head removal, empty walks.
  task automatic test_directed();
    send_item(OP_SELECT, 6'd0, 1'b0, 16'd0, '1);
    send_item(OP_RESET_WALK, 6'd63, 1'b1, 16'hFFFF, '0);
    send_item(OP_UNREGISTER, 6'd5, 1'b0, 16'd0, '0);
    for (int i = 0; i < 16; i++)
      send_item(OP_REGISTER, 6'(i * 4 + 3), 1'(i % 2),
                (i == 0) ? 16'hFFFF : (i == 1) ? 16'd0 : 16'(i % 3 * 100), '0);
    send_item(OP_REGISTER, 6'd3, 1'b0, 16'd5, '0);
    send_item(OP_REGISTER, 6'd0, 1'b1, 16'd5, '0);
    send_item(OP_RESET_WALK, 6'd0, 1'b0, 16'd0, '0);
    send_item(OP_SELECT, 6'd0, 1'b0, 16'd0, 64'h8000_0000_0000_0000);
    send_item(OP_UNREGISTER, 6'd3, 1'b0, 16'd0, '0);
    send_item(OP_SELECT, 6'd0, 1'b0, 16'd0, '1);
    send_item(OP_SELECT, 6'd0, 1'b0, 16'd0, '0);
  endtask

  // Mostly live ids so that hits, duplicates and a full table are common.
  task automatic test_random(int count);
    op_t op;
    for (int k = 0; k < count; k++) begin
      op = op_t'($urandom_range(3, 0));
      if ($urandom_range(9, 0) < 5) op = ($urandom_range(1, 0) != 0) ? OP_REGISTER : OP_SELECT;
      send_item(op,
                ($urandom_range(3, 0) == 0) ? 6'($urandom()) : 6'($urandom_range(23, 0)),
                1'($urandom()),
                ($urandom_range(3, 0) == 0) ? 16'($urandom()) : 16'($urandom_range(4, 0)),
                ($urandom_range(1, 0) != 0) ? rand_mask() : (64'd1 << $urandom_range(23, 0)));
    end
  endtask

  // The sender holds off until all results are in, then continues.
  task automatic test_quiet_sender();
    send_item(OP_RESET_WALK, 6'd1, 1'b0, 16'd0, '0);
    wait_drained();
    send_item(OP_SELECT, 6'd0, 1'b0, 16'd0, rand_mask());
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    tbl_head = NIL;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_prio[i] = '0;
      tbl_flag[i] = 1'b0;
      tbl_next[i] = 0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = '0;
    in_behavior_id = '0;
    in_has_reset = 1'b0;
    in_priority_req = '0;
    in_request_mask = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100);
    test_quiet_sender();
    send_idle_pct = 83;
    test_random(95);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    test_random(95);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    test_random(95);
    wait_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_priority_behavior_table_core: clean");
    end else begin
      $display("tb_priority_behavior_table_core: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_priority_behavior_table_core: errors");
    $finish;
  end

endmodule
